// File: sv/gtg_pkg.sv
// Shared types, constants and the microcode ROM for the go-to-goal drive block.
// Used by gtg_seq, gtg_dpath and the top level; depends on nothing else.

package gtg_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_GOAL_X         = 3'd0;
  localparam logic [2:0] REG_GOAL_Y         = 3'd1;
  localparam logic [2:0] REG_STOP_DISTANCE  = 3'd2;
  localparam logic [2:0] REG_ANGLE_DEADBAND = 3'd3;
  localparam logic [2:0] REG_OBSTACLE_RANGE = 3'd4;

  // Reset values of the registers
  localparam logic signed [15:0] GOAL_X_RST         = 16'sd5965;
  localparam logic signed [15:0] GOAL_Y_RST         = -16'sd9728;
  localparam logic [15:0]        STOP_DISTANCE_RST  = 16'd102;
  localparam logic [14:0]        ANGLE_DEADBAND_RST = 15'd819;
  localparam logic [15:0]        OBSTACLE_RANGE_RST = 16'd77;

  // Request kinds
  localparam logic [1:0] REQ_POSE  = 2'd0;
  localparam logic [1:0] REQ_RANGE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Arithmetic constants
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [19:0] Z_ROUND     = 20'sd8;
  // floor(n / 10) = (n * 209716) >> 21, exact for n < 2^18
  localparam logic signed [18:0] RECIP_TEN   = 19'sd209716;

  // Iteration counter
  localparam int CNT_W       = 5;
  localparam int ROOT_STEPS  = 17;
  localparam int CORD_STEPS  = 16;
  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);
  localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORD_STEPS - 1);

  // Microprogram step addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] S_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] S_DIFF  = 4'd1;
  localparam logic [PC_W-1:0] S_SQX   = 4'd2;
  localparam logic [PC_W-1:0] S_SQY   = 4'd3;
  localparam logic [PC_W-1:0] S_SUM   = 4'd4;
  localparam logic [PC_W-1:0] S_ROOT  = 4'd5;
  localparam logic [PC_W-1:0] S_RECIP = 4'd6;
  localparam logic [PC_W-1:0] S_LIN   = 4'd7;
  localparam logic [PC_W-1:0] S_CINIT = 4'd8;
  localparam logic [PC_W-1:0] S_CITER = 4'd9;
  localparam logic [PC_W-1:0] S_CDONE = 4'd10;
  localparam logic [PC_W-1:0] S_ZHEAD = 4'd11;
  localparam logic [PC_W-1:0] S_ANG   = 4'd12;
  localparam logic [PC_W-1:0] S_FINAL = 4'd13;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_DIFF,
    OP_SQX,
    OP_SQY,
    OP_SUM,
    OP_ROOT,
    OP_RECIP,
    OP_LIN,
    OP_CINIT,
    OP_CITER,
    OP_CDONE,
    OP_ZHEAD,
    OP_ANG,
    OP_FINAL
  } op_t;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NOT_TICK,
    C_POS_ZERO,
    C_LATCHED,
    C_ZERO_VEC,
    C_ROOT_MORE,
    C_CORD_MORE,
    C_OUT_BUSY
  } cond_t;

  // One microcode word: datapath operation, jump condition and target,
  // and a flag that sends a fall-through back to idle.
  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            done;
  } ctl_t;

  typedef struct packed {
    logic pos_zero;
    logic zero_vec;
    logic latched;
  } dp_stat_t;

  typedef struct packed {
    logic     tick_in;
    logic     out_busy;
    dp_stat_t dp;
  } seq_stat_t;

  function automatic ctl_t gtg_rom(input logic [PC_W-1:0] pc);
    ctl_t w;
    case (pc)
      S_IDLE:  w = '{OP_IDLE,  C_NOT_TICK,  S_IDLE,  1'b0};
      S_DIFF:  w = '{OP_DIFF,  C_POS_ZERO,  S_FINAL, 1'b0};
      S_SQX:   w = '{OP_SQX,   C_NONE,      S_IDLE,  1'b0};
      S_SQY:   w = '{OP_SQY,   C_NONE,      S_IDLE,  1'b0};
      S_SUM:   w = '{OP_SUM,   C_NONE,      S_IDLE,  1'b0};
      S_ROOT:  w = '{OP_ROOT,  C_ROOT_MORE, S_ROOT,  1'b0};
      S_RECIP: w = '{OP_RECIP, C_NONE,      S_IDLE,  1'b0};
      S_LIN:   w = '{OP_LIN,   C_LATCHED,   S_ANG,   1'b0};
      S_CINIT: w = '{OP_CINIT, C_ZERO_VEC,  S_ZHEAD, 1'b0};
      S_CITER: w = '{OP_CITER, C_CORD_MORE, S_CITER, 1'b0};
      S_CDONE: w = '{OP_CDONE, C_ALWAYS,    S_ANG,   1'b0};
      S_ZHEAD: w = '{OP_ZHEAD, C_NONE,      S_IDLE,  1'b0};
      S_ANG:   w = '{OP_ANG,   C_NONE,      S_IDLE,  1'b0};
      S_FINAL: w = '{OP_FINAL, C_OUT_BUSY,  S_FINAL, 1'b1};
      default: w = '{OP_IDLE,  C_ALWAYS,    S_IDLE,  1'b0};
    endcase
    return w;
  endfunction

  // atan(2^-i) in Q.16, rounded
  function automatic logic [15:0] atan_q16(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0:    v = 16'd51472;
      4'd1:    v = 16'd30386;
      4'd2:    v = 16'd16055;
      4'd3:    v = 16'd8150;
      4'd4:    v = 16'd4091;
      4'd5:    v = 16'd2047;
      4'd6:    v = 16'd1024;
      4'd7:    v = 16'd512;
      4'd8:    v = 16'd256;
      4'd9:    v = 16'd128;
      4'd10:   v = 16'd64;
      4'd11:   v = 16'd32;
      4'd12:   v = 16'd16;
      4'd13:   v = 16'd8;
      4'd14:   v = 16'd4;
      4'd15:   v = 16'd2;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/gtg_seq.sv
// Microcode sequencer: step counter, iteration counter and jump logic.
// Reads the control ROM from gtg_pkg.

module gtg_seq import gtg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  seq_stat_t        stat,
  output ctl_t             ctl,
  output logic [CNT_W-1:0] cnt
);

  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             take;

  assign ctl = gtg_rom(pc_r);
  assign cnt = cnt_r;

  always_comb begin
    case (ctl.cond)
      C_NONE:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NOT_TICK:  take = !stat.tick_in;
      C_POS_ZERO:  take = stat.dp.pos_zero;
      C_LATCHED:   take = stat.dp.latched;
      C_ZERO_VEC:  take = stat.dp.zero_vec;
      C_ROOT_MORE: take = (cnt_r != ROOT_LAST);
      C_CORD_MORE: take = (cnt_r != CORD_LAST);
      C_OUT_BUSY:  take = stat.out_busy;
      default:     take = 1'b0;
    endcase

    if (take) begin
      pc_nxt = ctl.target;
    end else if (ctl.done) begin
      pc_nxt = S_IDLE;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end

    // count only inside the loop steps, clear everywhere else
    if (ctl.op == OP_ROOT || ctl.op == OP_CITER) begin
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= S_IDLE;
      cnt_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: sv/gtg_dpath.sv
// Datapath driven by the microcode word: multiplier, bit-serial square root,
// CORDIC vectoring and the command registers. Depends on gtg_pkg.

module gtg_dpath import gtg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_t               ctl,
  input  logic [CNT_W-1:0]   cnt,
  input  logic signed [15:0] goal_x,
  input  logic signed [15:0] goal_y,
  input  logic [15:0]        stop_distance,
  input  logic [14:0]        angle_deadband,
  input  logic signed [15:0] held_x,
  input  logic signed [15:0] held_y,
  input  logic signed [15:0] held_heading,
  input  logic               scan_close_flag,
  output dp_stat_t           stat,
  output logic [13:0]        linear_command,
  output logic signed [15:0] angular_command
);

  // payload registers
  logic signed [16:0] dx_r, dy_r;
  logic signed [37:0] prod_r;
  logic [33:0]        acc_r;
  logic [17:0]        rem_r;
  logic [16:0]        root_r;
  logic signed [33:0] x_r, y_r;
  logic signed [19:0] z_r;

  // architectural state
  logic signed [15:0] gh_r, gh_nxt;
  logic               latched_r;
  logic [13:0]        lin_r, lin_nxt;
  logic signed [15:0] ang_r, ang_nxt;

  logic signed [18:0] mul_a, mul_b;
  logic signed [37:0] prod_nxt;
  logic [19:0]        rem_sh, trial;
  logic               fits;
  logic signed [17:0] dx18, dy18, px, py;
  logic signed [19:0] pz, at, zr;
  logic [3:0]         sh;
  logic signed [33:0] xs, ys;
  logic               y_pos;
  logic signed [16:0] ang17;
  logic [16:0]        mag;

  assign stat.pos_zero = (held_x == 16'sd0) || (held_y == 16'sd0);
  assign stat.zero_vec = (dx_r == 17'sd0) && (dy_r == 17'sd0);
  assign stat.latched  = latched_r;

  assign linear_command  = lin_r;
  assign angular_command = ang_r;

  always_comb begin
    // multiplier operands
    case (ctl.op)
      OP_SQX: begin
        mul_a = {{2{dx_r[16]}}, dx_r};
        mul_b = mul_a;
      end
      OP_SQY: begin
        mul_a = {{2{dy_r[16]}}, dy_r};
        mul_b = mul_a;
      end
      default: begin
        mul_a = {2'b00, root_r};
        mul_b = RECIP_TEN;
      end
    endcase
    prod_nxt = mul_a * mul_b;

    // one root bit per step, two radicand bits in
    rem_sh = {rem_r, acc_r[33:32]};
    trial  = {1'b0, root_r, 2'b01};
    fits   = (rem_sh >= trial);

    // quarter turn when dx is negative
    dx18 = {dx_r[16], dx_r};
    dy18 = {dy_r[16], dy_r};
    if (dx_r[16]) begin
      if (!dy_r[16]) begin
        px = dy18;
        py = -dx18;
        pz = HALF_PI_Q16;
      end else begin
        px = -dy18;
        py = dx18;
        pz = -HALF_PI_Q16;
      end
    end else begin
      px = dx18;
      py = dy18;
      pz = 20'sd0;
    end

    sh    = cnt[3:0];
    xs    = x_r >>> sh;
    ys    = y_r >>> sh;
    at    = signed'({4'b0000, atan_q16(sh)});
    y_pos = (y_r > 34'sd0);

    zr = z_r + Z_ROUND;

    ang17 = {gh_r[15], gh_r} - {held_heading[15], held_heading};
    mag   = ang17[16] ? 17'(-ang17) : 17'(ang17);

    gh_nxt  = gh_r;
    lin_nxt = lin_r;
    ang_nxt = ang_r;
    case (ctl.op)
      OP_LIN: begin
        lin_nxt = (root_r < {1'b0, stop_distance}) ? 14'd0 : prod_r[34:21];
      end
      OP_CDONE: gh_nxt = zr[19:4];
      OP_ZHEAD: gh_nxt = 16'sd0;
      OP_ANG: begin
        ang_nxt = (mag < {2'b00, angle_deadband}) ? 16'sd0 : ang17[15:0];
      end
      OP_FINAL: begin
        if (scan_close_flag) begin
          lin_nxt = 14'd0;
          ang_nxt = 16'sd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_DIFF: begin
        dx_r <= {goal_x[15], goal_x} - {held_x[15], held_x};
        dy_r <= {goal_y[15], goal_y} - {held_y[15], held_y};
      end
      OP_SQX:   prod_r <= prod_nxt;
      OP_SQY: begin
        acc_r  <= prod_r[33:0];
        prod_r <= prod_nxt;
      end
      OP_SUM: begin
        acc_r  <= acc_r + prod_r[33:0];
        rem_r  <= '0;
        root_r <= '0;
      end
      OP_ROOT: begin
        acc_r <= {acc_r[31:0], 2'b00};
        if (fits) begin
          rem_r  <= 18'(rem_sh - trial);
          root_r <= {root_r[15:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[17:0];
          root_r <= {root_r[15:0], 1'b0};
        end
      end
      OP_RECIP: prod_r <= prod_nxt;
      OP_CINIT: begin
        x_r <= {{2{px[17]}}, px, 14'd0};
        y_r <= {{2{py[17]}}, py, 14'd0};
        z_r <= pz;
      end
      OP_CITER: begin
        if (y_pos) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gh_r      <= '0;
      latched_r <= 1'b0;
      lin_r     <= '0;
      ang_r     <= '0;
    end else begin
      gh_r  <= gh_nxt;
      lin_r <= lin_nxt;
      ang_r <= ang_nxt;
      if (ctl.op == OP_CDONE || ctl.op == OP_ZHEAD) begin
        latched_r <= 1'b1;
      end
    end
  end

endmodule

// File: sv/go_to_goal_drive_with_obstacle_stop_top.sv
// Channel   Dir  Handshake             Payload
// in_       in   tvalid/tready         tuser=req_type, tdata=pose/range, tlast=last_in_scan
// out_      out  tvalid/tready         tdata=linear/angular/obstacle_stop
// cfg_      in   we, no back-pressure  addr=register index, wdata
//
// Pose and range items complete at accept. A control tick runs the microprogram:
// difference, squares, sum, the 17-step root loop, reciprocal and linear command;
// on the tick that latches the goal heading, the 16-step CORDIC loop unless the
// goal vector is zero; then the angular command. A zero x or y pose skips to output.
// Reset is synchronous; no clearing pass. A tick's last step holds while the
// output register is full and not being taken; input waits until then.

module go_to_goal_drive_with_obstacle_stop_top import gtg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // pose_x[15:0], pose_y[31:16], pose_heading[46:32],
                                  // range_value[62:47], zero[63]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  input  logic        in_tlast,   // last_in_scan
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // linear_speed[13:0], angular_speed[29:14],
                                  // obstacle_stop[30], zero[31]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic signed [15:0] goal_x_r, goal_y_r;
  logic [15:0]        stop_distance_r, obstacle_range_r;
  logic [14:0]        angle_deadband_r;

  logic signed [15:0] held_x_r, held_y_r, held_heading_r;
  logic               pending_r, flag_r, pending_nxt;

  logic               out_tvalid_r;
  logic [31:0]        out_tdata_r, out_tdata_nxt;

  ctl_t               ctl;
  logic [CNT_W-1:0]   cnt;
  dp_stat_t           dp_stat;
  seq_stat_t          seq_stat;
  logic [13:0]        lin_cmd;
  logic signed [15:0] ang_cmd;

  logic               in_acc, out_busy, out_load;
  logic [14:0]        in_heading;
  logic [15:0]        in_range;

  assign in_tready  = (ctl.op == OP_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_heading = in_tdata[46:32];
  assign in_range   = in_tdata[62:47];

  assign out_busy = out_tvalid_r && !out_tready;
  assign out_load = (ctl.op == OP_FINAL) && !out_busy;

  assign seq_stat.tick_in  = in_acc && (in_tuser == REQ_TICK);
  assign seq_stat.out_busy = out_busy;
  assign seq_stat.dp       = dp_stat;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  gtg_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (seq_stat),
    .ctl   (ctl),
    .cnt   (cnt)
  );

  gtg_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .cnt             (cnt),
    .goal_x          (goal_x_r),
    .goal_y          (goal_y_r),
    .stop_distance   (stop_distance_r),
    .angle_deadband  (angle_deadband_r),
    .held_x          (held_x_r),
    .held_y          (held_y_r),
    .held_heading    (held_heading_r),
    .scan_close_flag (flag_r),
    .stat            (dp_stat),
    .linear_command  (lin_cmd),
    .angular_command (ang_cmd)
  );

  always_comb begin
    pending_nxt = pending_r || (in_range <= obstacle_range_r);
    if (flag_r) begin
      out_tdata_nxt = {1'b0, 1'b1, 16'd0, 14'd0};
    end else begin
      out_tdata_nxt = {1'b0, 1'b0, ang_cmd, lin_cmd};
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r         <= GOAL_X_RST;
      goal_y_r         <= GOAL_Y_RST;
      stop_distance_r  <= STOP_DISTANCE_RST;
      angle_deadband_r <= ANGLE_DEADBAND_RST;
      obstacle_range_r <= OBSTACLE_RANGE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GOAL_X:         goal_x_r         <= cfg_wdata;
        REG_GOAL_Y:         goal_y_r         <= cfg_wdata;
        REG_STOP_DISTANCE:  stop_distance_r  <= cfg_wdata;
        REG_ANGLE_DEADBAND: angle_deadband_r <= cfg_wdata[14:0];
        REG_OBSTACLE_RANGE: obstacle_range_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pose and scan items complete at accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_x_r       <= '0;
      held_y_r       <= '0;
      held_heading_r <= '0;
      pending_r      <= 1'b0;
      flag_r         <= 1'b0;
    end else if (in_acc) begin
      case (in_tuser)
        REQ_POSE: begin
          held_x_r       <= in_tdata[15:0];
          held_y_r       <= in_tdata[31:16];
          held_heading_r <= {in_heading[14], in_heading};
        end
        REQ_RANGE: begin
          if (in_tlast) begin
            flag_r    <= pending_nxt;
            pending_r <= 1'b0;
          end else begin
            pending_r <= pending_nxt;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

endmodule

// File: sim/testbench.sv
// Self-checking bench for go_to_goal_drive_with_obstacle_stop_top: stream driver, result
// monitor and an in-bench predictor of the drive commands (distance, CORDIC bearing, scan).
// Depends on gtg_pkg for request kinds, register indexes, reset values and the half-pi constant.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gtg_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int LIMIT        = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_HOLD    = 400;

  localparam longint BEAM_ATAN [16] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [14:0] hdg;
    logic [15:0]        rng;
    logic               tail;
  } drive_req_t;

  typedef struct {
    logic [13:0] lin;
    logic [15:0] ang;
    logic        stop;
  } drive_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  go_to_goal_drive_with_obstacle_stop_top uut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  // Predictor copy of the registers and state
  logic signed [15:0] tgt_x = GOAL_X_RST;
  logic signed [15:0] tgt_y = GOAL_Y_RST;
  logic [15:0]        stop_dist = STOP_DISTANCE_RST;
  logic [14:0]        turn_band = ANGLE_DEADBAND_RST;
  logic [15:0]        near_range = OBSTACLE_RANGE_RST;
  logic signed [15:0] pos_x = '0, pos_y = '0, pos_hdg = '0;
  longint             bearing = 0;
  bit                 bearing_set = 1'b0;
  logic [13:0]        lin_hold = '0;
  logic [15:0]        ang_hold = '0;
  bit                 near_seen = 1'b0, near_flag = 1'b0;

  drive_req_t drive_reqs[$];
  drive_cmd_t cmd_expect[$];
  drive_req_t cur_req;
  bit in_hold = 1'b0;
  int in_gap = 0;
  int ready_stall = 0;
  bit ready_hold_req = 1'b0;
  bit idle_on = 1'b1;
  int cycle_count = 0;
  int mismatches = 0;
  int reqs_taken = 0;
  int cmds_checked = 0;
  int settings_run = 0;

  function automatic longint root_floor34(input longint n);
    longint r, t;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic longint goal_bearing(input longint dx, input longint dy);
    longint x, y, z, xs, ys;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (dx < 0) begin
      if (dy >= 0) begin
        x = dy; y = -dx; z = longint'(HALF_PI_Q16);
      end else begin
        x = -dy; y = dx; z = -longint'(HALF_PI_Q16);
      end
    end else begin
      x = dx; y = dy;
    end
    x = x * 16384;
    y = y * 16384;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += BEAM_ATAN[i];
      end else begin
        x -= ys; y += xs; z -= BEAM_ATAN[i];
      end
    end
    return (z + 8) >>> 4;
  endfunction

  // Advance the predicted state by one item; returns 1 when a command is due
  function automatic bit plan_drive_cmd(input drive_req_t r, output drive_cmd_t c);
    longint dx, dy, reach, err, mag;
    c = '{lin: '0, ang: '0, stop: 1'b0};
    case (r.kind)
      REQ_POSE: begin
        pos_x = r.px;
        pos_y = r.py;
        pos_hdg = r.hdg;
        return 1'b0;
      end
      REQ_RANGE: begin
        if (r.rng <= near_range) near_seen = 1'b1;
        if (r.tail) begin
          near_flag = near_seen;
          near_seen = 1'b0;
        end
        return 1'b0;
      end
      REQ_TICK: ;
      default: return 1'b0;
    endcase
    if (pos_x != 0 && pos_y != 0) begin
      dx = longint'(tgt_x) - longint'(pos_x);
      dy = longint'(tgt_y) - longint'(pos_y);
      reach = root_floor34(dx * dx + dy * dy);
      if (!bearing_set) begin
        bearing = goal_bearing(dx, dy);
        bearing_set = 1'b1;
      end
      lin_hold = (reach < longint'(stop_dist)) ? 14'd0 : 14'(reach / 10);
      err = bearing - longint'(pos_hdg);
      mag = (err < 0) ? -err : err;
      ang_hold = (mag < longint'(turn_band)) ? 16'd0 : 16'(err);
    end
    if (near_flag) begin
      lin_hold = '0;
      ang_hold = '0;
    end
    c.lin = lin_hold;
    c.ang = ang_hold;
    c.stop = near_flag;
    return 1'b1;
  endfunction

  function automatic void push_pose(input logic [15:0] x, input logic [15:0] y,
                                    input logic [14:0] h);
    drive_req_t r;
    r = '{kind: REQ_POSE, px: x, py: y, hdg: h, rng: 16'($urandom), tail: 1'($urandom)};
    drive_reqs.push_back(r);
  endfunction

  function automatic void push_range(input logic [15:0] v, input logic t);
    drive_req_t r;
    r = '{kind: REQ_RANGE, px: 16'($urandom), py: 16'($urandom), hdg: 15'($urandom),
          rng: v, tail: t};
    drive_reqs.push_back(r);
  endfunction

  function automatic void push_other(input logic [1:0] k);
    drive_req_t r;
    r = '{kind: k, px: 16'($urandom), py: 16'($urandom), hdg: 15'($urandom),
          rng: 16'($urandom), tail: 1'($urandom)};
    drive_reqs.push_back(r);
  endfunction

  // Mostly pose / scan / tick traffic, with poses near the goal and ranges near
  // the obstacle threshold to hit the comparison edges
  function automatic void queue_random_reqs(input int n);
    int made, sel;
    logic [15:0] x, y;
    logic [14:0] h;
    logic [15:0] v;
    made = 0;
    while (made < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 28) begin
        x = 16'($urandom);
        y = 16'($urandom);
        if ($urandom_range(0, 6) == 0) begin
          x = 16'(int'(tgt_x) + int'($urandom_range(0, 600)) - 300);
          y = 16'(int'(tgt_y) + int'($urandom_range(0, 600)) - 300);
        end
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1) == 0) x = '0;
          else y = '0;
        end
        h = 15'(int'($urandom_range(0, 25736)) - 12868);
        push_pose(x, y, h);
        made++;
      end else if (sel < 63) begin
        v = 16'($urandom);
        if ($urandom_range(0, 4) == 0) v = 16'(int'(near_range) + int'($urandom_range(0, 4)) - 2);
        push_range(v, $urandom_range(0, 3) == 0);
        made++;
      end else if (sel < 96) begin
        push_other(REQ_TICK);
        made++;
      end else begin
        push_other(REQ_UNUSED);
      end
    end
  endfunction

  task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_GOAL_X:         tgt_x = val;
      REG_GOAL_Y:         tgt_y = val;
      REG_STOP_DISTANCE:  stop_dist = val;
      REG_ANGLE_DEADBAND: turn_band = val[14:0];
      REG_OBSTACLE_RANGE: near_range = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setting(input logic [15:0] gx, input logic [15:0] gy,
                              input logic [15:0] sd, input logic [15:0] db,
                              input logic [15:0] orng);
    set_reg(REG_GOAL_X, gx);
    set_reg(REG_GOAL_Y, gy);
    set_reg(REG_STOP_DISTANCE, sd);
    set_reg(REG_ANGLE_DEADBAND, db);
    set_reg(REG_OBSTACLE_RANGE, orng);
    settings_run++;
  endtask

  // Hold until every item is taken and every command has come back
  task automatic settle();
    while (drive_reqs.size() != 0 || in_hold || cmd_expect.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Input driver
  always @(negedge clk) begin
    if (rst_n && !in_hold) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (drive_reqs.size() != 0) begin
        if (idle_on && $urandom_range(0, 4) == 0) begin
          in_gap = $urandom_range(0, 9);
          in_tvalid <= 1'b0;
        end else begin
          cur_req = drive_reqs.pop_front();
          in_hold = 1'b1;
          in_tvalid <= 1'b1;
          in_tuser <= cur_req.kind;
          in_tlast <= cur_req.tail;
          in_tdata <= {1'b0, cur_req.rng, cur_req.hdg, cur_req.py, cur_req.px};
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result-side ready, with random stalls and one long hold-off on request
  always @(negedge clk) begin
    if (ready_stall > 0) begin
      ready_stall--;
      out_tready <= 1'b0;
    end else if (ready_hold_req) begin
      ready_hold_req = 1'b0;
      ready_stall = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      ready_stall = $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: predict on input accept, check on output accept
  always @(posedge clk) begin
    drive_cmd_t c, want;
    if (rst_n) begin
      cycle_count++;
      if (in_tvalid && in_tready) begin
        if (plan_drive_cmd(cur_req, c)) cmd_expect.push_back(c);
        in_hold = 1'b0;
        reqs_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (cmd_expect.size() == 0) begin
          $display("%0t: unexpected command lin=%0d ang=%0d stop=%0d", $time,
                   out_tdata[13:0], $signed(out_tdata[29:14]), out_tdata[30]);
          mismatches++;
        end else begin
          want = cmd_expect.pop_front();
          cmds_checked++;
          if (out_tdata[13:0] !== want.lin) begin
            $display("%0t: linear_speed expected %0d got %0d", $time, want.lin,
                     out_tdata[13:0]);
            mismatches++;
          end
          if (out_tdata[29:14] !== want.ang) begin
            $display("%0t: angular_speed expected %0d got %0d", $time,
                     $signed(want.ang), $signed(out_tdata[29:14]));
            mismatches++;
          end
          if (out_tdata[30] !== want.stop) begin
            $display("%0t: obstacle_stop expected %0d got %0d", $time, want.stop,
                     out_tdata[30]);
            mismatches++;
          end
        end
      end
      if (cycle_count > LIMIT) begin
        $display("%0t: cycle limit reached, %0d commands outstanding", $time,
                 cmd_expect.size());
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset registers
    push_other(REQ_TICK);                      // no pose yet
    push_pose(16'd0, 16'd500, 15'd100);        // zero x leaves commands alone
    push_other(REQ_TICK);
    push_pose(GOAL_X_RST, GOAL_Y_RST, 15'd0);  // pose on the goal: zero vector bearing
    push_other(REQ_TICK);
    push_pose(GOAL_X_RST, 16'(GOAL_Y_RST + 16'sd102), 15'd818);  // distance equals stop
    push_other(REQ_TICK);
    push_pose(16'(GOAL_X_RST - 16'sd101), GOAL_Y_RST, 15'd819);  // edge of deadband
    push_other(REQ_TICK);
    push_pose(16'h8000, 16'h7FFF, 15'd12868);
    push_other(REQ_TICK);
    push_pose(16'h7FFF, 16'h8000, 15'(-12868));
    push_other(REQ_TICK);
    push_range(16'd78, 1'b0);
    push_range(16'd77, 1'b1);                  // beam at threshold closes the scan
    push_other(REQ_TICK);
    push_range(16'hFFFF, 1'b1);                // clear scan
    push_other(REQ_TICK);
    push_range(16'd0, 1'b0);
    push_range(16'hFFFF, 1'b0);
    push_range(16'hFFFF, 1'b1);
    push_other(REQ_TICK);
    push_other(REQ_UNUSED);
    push_range(16'd1000, 1'b1);
    push_other(REQ_TICK);
    settle();

    // Extremes of every register
    load_setting(16'h8000, 16'h8000, 16'd0, 16'd0, 16'd0);
    queue_random_reqs(100);
    settle();
    load_setting(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_random_reqs(80);
    settle();

    for (int p = 0; p < 6; p++) begin
      load_setting(16'($urandom), 16'($urandom), 16'($urandom_range(0, 4000)),
                   ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000)),
                   16'($urandom_range(0, 2000)));
      if (p == 1) ready_hold_req = 1'b1;
      if (p == 5) idle_on = 1'b0;
      queue_random_reqs(128);
      settle();
    end

    $display("Covered %0d items and %0d checked commands over %0d register settings,",
             reqs_taken, cmds_checked, settings_run + 1);
    $display("including scan stops, deadband and stop-distance edges and a long output stall.");
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/gtg_pkg.sv
sv/gtg_seq.sv
sv/gtg_dpath.sv
sv/go_to_goal_drive_with_obstacle_stop_top.sv
sim/testbench.sv
